@@ rtl/core/max_ones_rectangle_area_assert.svh @@
// Assertion macros shared by the rectangle area block.
`ifndef MAX_ONES_RECTANGLE_AREA_ASSERT_SVH
`define MAX_ONES_RECTANGLE_AREA_ASSERT_SVH
`ifndef ASSERT_OFF
`define MORA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MORA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MORA_ASSERT_IMP(lbl, ante, cons, msg)
`define MORA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/mora_pkg.sv @@
// Shared types and constants of the rectangle area block.
package mora_pkg;
  localparam int unsigned DEF_MAX_COLS = 1024;
  localparam int unsigned HEIGHT_W     = 11;
  localparam int unsigned AREA_W       = 21;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned POS_W        = 12;
  localparam int unsigned CNT_W        = POS_W + 1;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
  localparam logic [AREA_W-1:0]   AREA_MAX   = '1;
  localparam logic [CFG_W-1:0]    COLS_RESET = 11'd1024;

  typedef struct packed {
    logic             filled;
    logic             last;
    logic             row_end;
    logic [POS_W-1:0] pos;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]    start;
    logic [HEIGHT_W-1:0] h;
  } stk_t;

  typedef enum logic [8:0] {
    ST_INIT = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_UPD  = 9'b000000100,
    ST_RD   = 9'b000001000,
    ST_LD   = 9'b000010000,
    ST_CMP  = 9'b000100000,
    ST_POP  = 9'b001000000,
    ST_EMIT = 9'b010000000,
    ST_CLR  = 9'b100000000
  } state_e;
endpackage

@@ rtl/core/mora_front.sv @@
// Input side: takes cells, tracks the column position and marks row ends.
module mora_front #(
  parameter int unsigned MAX_COLS = mora_pkg::DEF_MAX_COLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mora_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       cell_i,
  input  logic                       last_i,
  input  logic                       full_i,
  input  logic                       hold_i,
  output logic                       push_o,
  output mora_pkg::item_t            item_o
);
  import mora_pkg::*;

  logic [CFG_W-1:0] num_cols_q;
  logic [POS_W-1:0] col_pos_q, col_pos_d, pos;
  logic [CNT_W-1:0] ncfg, n, pos_next;
  logic             row_end;

  always_comb begin
    ncfg = CNT_W'(num_cols_q);
    if (ncfg == '0) begin
      n = CNT_W'(1);
    end else if (ncfg > CNT_W'(MAX_COLS)) begin
      n = CNT_W'(MAX_COLS);
    end else begin
      n = ncfg;
    end
    if (CNT_W'(col_pos_q) >= CNT_W'(MAX_COLS)) begin
      pos = POS_W'(MAX_COLS - 1);
    end else begin
      pos = col_pos_q;
    end
    pos_next  = CNT_W'(pos) + CNT_W'(1);
    row_end   = last_i || (pos_next >= n);
    col_pos_d = row_end ? '0 : pos_next[POS_W-1:0];
  end

  assign ready_o = !full_i && !hold_i;
  assign push_o  = valid_i && ready_o;
  assign item_o  = '{filled: cell_i, last: last_i, row_end: row_end, pos: pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= COLS_RESET;
      col_pos_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        num_cols_q <= cfg_wdata_i;
      end
      if (push_o) begin
        col_pos_q <= col_pos_d;
      end
    end
  end
endmodule

@@ rtl/core/mora_fifo.sv @@
// Short queue of classified cells between the input side and the engine.
module mora_fifo #(
  parameter int unsigned DEPTH = mora_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mora_pkg::item_t item_i,
  input  logic            pop_i,
  output mora_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);
  import mora_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             mem_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [PW:0]       cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end
endmodule

@@ rtl/core/mora_back.sv @@
// Engine: updates column heights and scans each finished row with a stack.
module mora_back #(
  parameter int unsigned MAX_COLS = mora_pkg::DEF_MAX_COLS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  mora_pkg::item_t             item_i,
  output logic                        pop_o,
  output logic                        init_busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mora_pkg::AREA_W-1:0] out_data_o
);
  import mora_pkg::*;

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned PW = HEIGHT_W + CNT_W;

  logic [HEIGHT_W-1:0] hmem [MAX_COLS];
  stk_t                smem [MAX_COLS];

  state_e              state_q;
  item_t               cur_q;
  logic [CNT_W-1:0]    i_q, len_q, sp_q, clr_q;
  stk_t                top_q;
  logic [HEIGHT_W-1:0] curh_q, h_rdata_q;
  logic [POS_W-1:0]    start_q;
  stk_t                s_rdata_q;
  logic [PW-1:0]       prod_q;
  logic                prod_vld_q;
  logic [AREA_W-1:0]   best_q, out_data_q, prod_sat;
  logic                out_valid_q;

  logic                h_re, h_we, s_re, s_we, do_pop;
  logic [AW-1:0]       h_raddr, h_waddr, s_raddr, s_waddr;
  logic [HEIGHT_W-1:0] h_wdata;

  assign do_pop   = (sp_q != '0) && (top_q.h >= curh_q);
  assign prod_sat = (prod_q > PW'(AREA_MAX)) ? AREA_MAX : prod_q[AREA_W-1:0];

  always_comb begin
    h_re    = 1'b0;
    h_we    = 1'b0;
    s_re    = 1'b0;
    s_we    = 1'b0;
    pop_o   = 1'b0;
    h_raddr = '0;
    h_waddr = '0;
    h_wdata = '0;
    s_raddr = '0;
    s_waddr = '0;
    case (state_q)
      ST_INIT, ST_CLR: begin
        h_we    = 1'b1;
        h_waddr = clr_q[AW-1:0];
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          h_re    = 1'b1;
          h_raddr = item_i.pos[AW-1:0];
        end
      end
      ST_UPD: begin
        h_we    = 1'b1;
        h_waddr = cur_q.pos[AW-1:0];
        if (cur_q.filled) begin
          h_wdata = (h_rdata_q == HEIGHT_MAX) ? h_rdata_q : h_rdata_q + HEIGHT_W'(1);
        end
      end
      ST_RD: begin
        h_re    = 1'b1;
        h_raddr = i_q[AW-1:0];
      end
      ST_CMP: begin
        // The entry under the top is fetched when a pop leaves a non-empty stack.
        if (do_pop && sp_q >= CNT_W'(2)) begin
          s_re    = 1'b1;
          s_raddr = AW'(sp_q - CNT_W'(2));
        end else if (!do_pop && i_q < len_q && sp_q != '0) begin
          s_we    = 1'b1;
          s_waddr = AW'(sp_q - CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      h_rdata_q <= hmem[h_raddr];
    end
    if (s_we) begin
      smem[s_waddr] <= top_q;
    end
    if (s_re) begin
      s_rdata_q <= smem[s_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      i_q         <= '0;
      len_q       <= '0;
      sp_q        <= '0;
      prod_vld_q  <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_vld_q <= 1'b0;
      if (prod_vld_q && prod_sat > best_q) begin
        best_q <= prod_sat;
      end
      if (out_ready_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT, ST_CLR: begin
          if (clr_q == CNT_W'(MAX_COLS - 1)) begin
            clr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (!empty_i) begin
            cur_q   <= item_i;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (cur_q.row_end) begin
            i_q     <= '0;
            len_q   <= CNT_W'(cur_q.pos) + CNT_W'(1);
            sp_q    <= '0;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_RD: begin
          state_q <= ST_LD;
        end
        ST_LD: begin
          curh_q  <= (i_q < len_q) ? h_rdata_q : '0;
          start_q <= i_q[POS_W-1:0];
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (do_pop) begin
            prod_q     <= PW'(top_q.h) * PW'(i_q - CNT_W'(top_q.start));
            prod_vld_q <= 1'b1;
            start_q    <= top_q.start;
            sp_q       <= sp_q - CNT_W'(1);
            state_q    <= (sp_q >= CNT_W'(2)) ? ST_POP : ST_CMP;
          end else if (i_q < len_q) begin
            top_q   <= '{start: start_q, h: curh_q};
            sp_q    <= sp_q + CNT_W'(1);
            i_q     <= i_q + CNT_W'(1);
            state_q <= ST_RD;
          end else begin
            state_q <= cur_q.last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_POP: begin
          top_q   <= s_rdata_q;
          state_q <= ST_CMP;
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= best_q;
            best_q      <= '0;
            clr_q       <= '0;
            state_q     <= ST_CLR;
          end
        end
        default: state_q <= ST_INIT;
      endcase
    end
  end

  assign init_busy_o = (state_q == ST_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
endmodule

@@ rtl/core/max_ones_rectangle_area.sv @@
// Top level of the largest all-ones rectangle block.
// Cells of a 0/1 matrix enter on the slave stream in row-major order, one per
// transaction: tdata bit 0 is the cell, tlast marks the final cell. The user
// must write the column count through cfg_we_i/cfg_wdata_i only while the
// block is idle; the block does not enforce this. After the final cell is
// processed, one master stream transaction carries the largest rectangle
// area; no other cell yields a result. A cell is queued after classification,
// then passes engine states IDLE and UPD for its height update. At each row
// end the engine scans the row's height histogram in states RD, LD and CMP
// per column and CMP, then POP unless the stack empties, per stack pop, using
// one height memory read port and one stack read and write port. After reset
// the height memory is cleared in ST_INIT with s_tready_o low; the same sweep
// follows every emitted result, while new cells still queue. The result sits
// in an output register: while the receiver stalls, the engine keeps working
// and only waits if a second result is ready before the first is taken.
module max_ones_rectangle_area #(
  parameter int unsigned MAX_COLS = mora_pkg::DEF_MAX_COLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mora_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [7:0]                 s_tdata_i,  // [0] cell_req, [7:1] zero
  input  logic                       s_tlast_i,  // last_cell
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [23:0]                m_tdata_o   // [20:0] max_area, [23:21] zero
);
  import mora_pkg::*;

  item_t             push_item, pop_item;
  logic              fifo_push, fifo_pop, fifo_full, fifo_empty, init_busy;
  logic [AREA_W-1:0] area;

  mora_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s_tvalid_i),
    .ready_o     (s_tready_o),
    .cell_i      (s_tdata_i[0]),
    .last_i      (s_tlast_i),
    .full_i      (fifo_full),
    .hold_i      (init_busy),
    .push_o      (fifo_push),
    .item_o      (push_item)
  );

  mora_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .item_i  (push_item),
    .pop_i   (fifo_pop),
    .item_o  (pop_item),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  mora_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .item_i      (pop_item),
    .pop_o       (fifo_pop),
    .init_busy_o (init_busy),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_data_o  (area)
  );

  assign m_tdata_o = {3'b000, area};

`include "max_ones_rectangle_area_assert.svh"

  `MORA_ASSERT_IMP(a_area_fits, m_tvalid_o, m_tdata_o[23:21] == 3'b000, "area pad bits set")
  `MORA_ASSERT_IMP(a_no_overflow, fifo_push, !fifo_full, "push into a full queue")
  `MORA_ASSERT_IMP(a_init_gate, init_busy, !s_tready_o, "cell taken during clearing")
  `MORA_ASSERT_IMP(a_pop_nonempty, fifo_pop, !fifo_empty, "pop from an empty queue")
endmodule

@@ sim/tb_max_ones_rectangle_area.sv @@
// Self-checking testbench for the largest all-ones rectangle block.
module tb_max_ones_rectangle_area;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCOLS_MAX = 1024;
  localparam int unsigned HMAX = 2047;
  localparam int unsigned AMAX = 2097151;
  localparam int unsigned IDLE_LIMIT = 200000;

  // Predictor of the matrix scan plus the queue of expected areas.
  class area_scoreboard;
    int unsigned width_reg;
    int unsigned heights[NCOLS_MAX];
    int unsigned pos;
    int unsigned best;
    int unsigned areas_due[$];
    int unsigned errors;

    function new();
      width_reg = 1024;
      pos = 0;
      best = 0;
      errors = 0;
      foreach (heights[k]) heights[k] = 0;
    endfunction

    function void scan_histogram(int unsigned len);
      int unsigned stk[$];
      int unsigned h;
      int unsigned top;
      int unsigned left;
      longint unsigned a;
      for (int unsigned i = 0; i <= len; i++) begin
        h = (i < len) ? heights[i] : 0;
        while (stk.size() > 0 && heights[stk[$]] >= h) begin
          top = stk.pop_back();
          left = (stk.size() > 0) ? stk[$] + 1 : 0;
          a = longint'(heights[top]) * (i - left);
          if (a > AMAX) a = AMAX;
          if (a > best) best = 32'(a);
        end
        if (i < len) stk.push_back(i);
      end
    endfunction

    function void note_cell(bit val, bit last);
      int unsigned n;
      int unsigned p;
      n = width_reg;
      if (n == 0) n = 1;
      if (n > NCOLS_MAX) n = NCOLS_MAX;
      p = (pos >= NCOLS_MAX) ? NCOLS_MAX - 1 : pos;
      if (val) begin
        if (heights[p] < HMAX) heights[p]++;
      end else begin
        heights[p] = 0;
      end
      if (last || p + 1 >= n) begin
        scan_histogram(p + 1);
        pos = 0;
      end else begin
        pos = p + 1;
      end
      if (last) begin
        areas_due.push_back(best);
        foreach (heights[k]) heights[k] = 0;
        best = 0;
        pos = 0;
      end
    endfunction

    function void check_area(logic [23:0] got);
      int unsigned want;
      if (areas_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result area %0d", got[20:0]);
        return;
      end
      want = areas_due.pop_front();
      if (got[20:0] !== want[20:0] || got[23:21] !== 3'b000) begin
        errors++;
        if (errors <= 10) $display("area mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = '0;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;

  area_scoreboard sb = new();
  bit          quiet_mode = 1'b0;  // no idling on either side
  bit          hold_off = 1'b0;
  int unsigned idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  max_ones_rectangle_area uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i(s_tvalid_i), .s_tready_o(s_tready_o), .s_tdata_i(s_tdata_i),
    .s_tlast_i(s_tlast_i), .m_tvalid_o(m_tvalid_o), .m_tready_i(m_tready_i),
    .m_tdata_o(m_tdata_o)
  );

  // Monitor and receiver side: random stalls unless in a quiet stretch or a hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) sb.check_area(m_tdata_o);
      if (s_tvalid_i && s_tready_o) sb.note_cell(s_tdata_i[0], s_tlast_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      m_tready_i <= !hold_off && (quiet_mode || $urandom_range(99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cell(bit val, bit last);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {7'b0, val};
    s_tlast_i <= last;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task automatic drain_and_config(int unsigned cols);
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.areas_due.size() > 0) @(posedge clk_i);
    // Cells after the last tlast leave no result; give the engine time to settle.
    repeat (20000) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cols[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.width_reg = cols;
  endtask

  task automatic send_matrix(int unsigned rows, int unsigned cols, int unsigned fill_pct);
    for (int unsigned r = 0; r < rows; r++)
      for (int unsigned c = 0; c < cols; c++)
        send_cell($urandom_range(99) < fill_pct, (r == rows - 1) && (c == cols - 1));
  endtask

  initial begin
    int unsigned cols;
    int unsigned rows;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a single all ones column, then small widths and edge counts.
    drain_and_config(1);
    send_matrix(3, 1, 100);
    send_cell(1'b0, 1'b1);
    drain_and_config(0);  // zero columns acts as one
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    drain_and_config(4);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);  // last cell mid-row
    send_matrix(2, 4, 0);
    drain_and_config(2047);  // above the maximum acts as the maximum
    send_matrix(1, 3, 100);
    send_cell(1'b1, 1'b1);

    // Receiver holds off while the sender keeps offering cells.
    drain_and_config(2);
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (6) send_matrix(2, 2, 80);
    join

    // Random matrices, one stretch without idling.
    for (int k = 0; k < 25; k++) begin
      quiet_mode = (k >= 10 && k < 16);
      cols = (k == 20) ? 1024 : $urandom_range(1, 8);
      rows = (k == 20) ? 1 : $urandom_range(1, 6);
      drain_and_config(cols);
      send_matrix(rows, cols, $urandom_range(40, 95));
      if ($urandom_range(3) == 0) send_cell($urandom_range(1), 1'b1);
    end
    quiet_mode = 1'b0;
    s_tvalid_i <= 1'b0;
    while (sb.areas_due.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
